@@ rtl/pchl_pkg.sv @@
// Shared types and codes for the palette color hash lookup.
// Used by pchl_ctrl, pchl_dp and the top level; no dependencies.
`default_nettype none

package pchl_pkg;

   // req_tuser: operation kind
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // rsp_tuser: result status
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND  = 2'd1;
   localparam logic [1:0] STATUS_NOT_LOADED = 2'd2;

   // response selection from controller to datapath
   localparam logic [1:0] RSP_LOAD       = 2'd0;
   localparam logic [1:0] RSP_FOUND      = 2'd1;
   localparam logic [1:0] RSP_MISS       = 2'd2;
   localparam logic [1:0] RSP_NOT_LOADED = 2'd3;

   typedef struct packed {
      logic       accept;       // latch request fields, form channel sum
      logic       hash_mult;    // reciprocal multiply stage
      logic       hash_reduce;  // remainder stage, writes hash register
      logic       clr_start;    // new palette: reset sweep counter, drop complete
      logic       clr_step;     // clear one bucket word
      logic       bkt_rd;       // read bucket word at hash
      logic       ld_write;     // write entry, end link and bucket word
      logic       link_write;   // link old tail to the new entry
      logic       walk_start;   // read entry at bucket head
      logic       walk_next;    // read entry at current link
      logic       rsp_load;     // fill response register
      logic [1:0] rsp_code;
   } pchl_cmd_type;

   typedef struct packed {
      logic is_lookup;
      logic complete;
      logic clear_last;
      logic used;
      logic match;
      logic next_end;
      logic rsp_busy;
   } pchl_sts_type;

endpackage

`default_nettype wire

@@ rtl/pchl_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module pchl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/pchl_ctrl.sv @@
// Sequencer for the palette color hash lookup: clear sweep, hash, load and chain walk.
// Depends on pchl_pkg; drives pchl_dp through pchl_cmd_type.
`default_nettype none

module pchl_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire pchl_pkg::pchl_sts_type sts,
   output pchl_pkg::pchl_cmd_type      cmd
);
   import pchl_pkg::*;

   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_HASH    = 4'd2;
   localparam logic [3:0] ST_REDUCE  = 4'd3;
   localparam logic [3:0] ST_NEWPAL  = 4'd4;
   localparam logic [3:0] ST_LD_RD   = 4'd5;
   localparam logic [3:0] ST_LD_WR   = 4'd6;
   localparam logic [3:0] ST_LD_LINK = 4'd7;
   localparam logic [3:0] ST_LK_RD   = 4'd8;
   localparam logic [3:0] ST_LK_HEAD = 4'd9;
   localparam logic [3:0] ST_LK_WALK = 4'd10;
   localparam logic [3:0] ST_RESP    = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [1:0] code_ff, code_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd      = '0;
      cmd.rsp_code = code_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_HASH;
            end
         end
         ST_HASH: begin
            cmd.hash_mult = 1'b1;
            state_in      = ST_REDUCE;
         end
         ST_REDUCE: begin
            cmd.hash_reduce = 1'b1;
            if (!sts.is_lookup) begin
               if (sts.complete) begin
                  cmd.clr_start = 1'b1;
                  state_in      = ST_NEWPAL;
               end else begin
                  state_in = ST_LD_RD;
               end
            end else if (sts.complete) begin
               state_in = ST_LK_RD;
            end else begin
               code_in  = RSP_NOT_LOADED;
               state_in = ST_RESP;
            end
         end
         ST_NEWPAL: begin
            cmd.clr_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_LD_RD;
            end
         end
         ST_LD_RD: begin
            cmd.bkt_rd = 1'b1;
            state_in   = ST_LD_WR;
         end
         ST_LD_WR: begin
            cmd.ld_write = 1'b1;
            code_in      = RSP_LOAD;
            state_in     = sts.used ? ST_LD_LINK : ST_RESP;
         end
         ST_LD_LINK: begin
            cmd.link_write = 1'b1;
            state_in       = ST_RESP;
         end
         ST_LK_RD: begin
            cmd.bkt_rd = 1'b1;
            state_in   = ST_LK_HEAD;
         end
         ST_LK_HEAD: begin
            if (sts.used) begin
               cmd.walk_start = 1'b1;
               state_in       = ST_LK_WALK;
            end else begin
               code_in  = RSP_MISS;
               state_in = ST_RESP;
            end
         end
         ST_LK_WALK: begin
            if (sts.match) begin
               code_in  = RSP_FOUND;
               state_in = ST_RESP;
            end else if (sts.next_end) begin
               code_in  = RSP_MISS;
               state_in = ST_RESP;
            end else begin
               cmd.walk_next = 1'b1;
            end
         end
         ST_RESP: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         code_ff  <= RSP_MISS;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

`ifndef SYNTHESIS
   a_rsp_not_over: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !sts.rsp_busy)
      else $error("response loaded over an untaken result");

   a_walk_data_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LK_WALK) |-> $past(cmd.walk_start || cmd.walk_next))
      else $error("chain compare without a preceding entry read");

   a_walk_stops_on_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_next |-> !sts.match && !sts.next_end)
      else $error("walk advanced past a hit or chain end");

   a_resp_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after a response");
`endif

endmodule

`default_nettype wire

@@ rtl/pchl_dp.sv @@
// Datapath: hash unit, entry/link/bucket memories, load position and response register.
// Depends on pchl_pkg and pchl_ram; controlled by pchl_ctrl.
`default_nettype none

module pchl_dp #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire pchl_pkg::pchl_cmd_type cmd,
   output pchl_pkg::pchl_sts_type      sts,
   input  wire logic                   req_tuser,
   input  wire logic [23:0]            req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [1:0]                  rsp_tuser,
   output logic [7:0]                  rsp_tdata
);
   import pchl_pkg::*;

   localparam int IW = $clog2(PALETTE_ENTRIES);
   localparam int LW = IW + 1;
   localparam int BW = 2 * IW + 1;
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP = ((1 << RECIP_SHIFT) + PALETTE_ENTRIES - 1) / PALETTE_ENTRIES;
   localparam logic [23:0] RECIP_V   = 24'(RECIP);
   localparam logic [22:0] ENTRIES_V = 23'(PALETTE_ENTRIES);
   localparam logic [LW-1:0] LINK_END = LW'(PALETTE_ENTRIES);
   localparam logic [IW-1:0] LAST_POS = IW'(PALETTE_ENTRIES - 1);

   logic          cmd_ff;
   logic [23:0]   colour_ff;
   logic [9:0]    sum_ff, sum_in;
   logic [33:0]   prod_ff, prod_in;
   logic [IW-1:0] hash_ff, hash_in;
   logic [22:0]   rem_raw, rem_fix;
   logic [IW-1:0] pos_ff, pos_in;
   logic          complete_ff, complete_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [7:0]    rsp_index_ff, rsp_index_in;

   logic [23:0]   colour_rd;
   logic [LW-1:0] link_rd;
   logic [BW-1:0] bkt_rd;
   logic          bkt_used;
   logic [IW-1:0] bkt_head, bkt_tail;

   logic          ent_rd_en;
   logic [IW-1:0] ent_rd_addr;
   logic          link_wr_en;
   logic [IW-1:0] link_wr_addr;
   logic [LW-1:0] link_wr_data;
   logic          bkt_wr_en;
   logic [IW-1:0] bkt_wr_addr;
   logic [BW-1:0] bkt_wr_data;

   assign bkt_used = bkt_rd[BW-1];
   assign bkt_head = bkt_rd[2*IW-1:IW];
   assign bkt_tail = bkt_rd[IW-1:0];

   // hash = (r + g + b) mod entries, by reciprocal multiply then remainder
   assign sum_in  = 10'(req_tdata[7:0]) + 10'(req_tdata[15:8]) + 10'(req_tdata[23:16]);
   assign prod_in = 34'(sum_ff) * 34'(RECIP_V);
   assign rem_raw = 23'(sum_ff) - 23'(prod_ff[33:24]) * ENTRIES_V;
   assign rem_fix = (rem_raw >= ENTRIES_V) ? (rem_raw - ENTRIES_V) : rem_raw;
   assign hash_in = IW'(rem_fix);

   // memory ports
   assign ent_rd_en   = cmd.walk_start | cmd.walk_next;
   assign ent_rd_addr = cmd.walk_start ? bkt_head : link_rd[IW-1:0];
   assign cur_in      = ent_rd_en ? ent_rd_addr : cur_ff;

   assign link_wr_en   = cmd.ld_write | cmd.link_write;
   assign link_wr_addr = cmd.link_write ? bkt_tail : pos_ff;
   assign link_wr_data = cmd.link_write ? LW'(pos_ff) : LINK_END;

   assign bkt_wr_en   = cmd.clr_step | cmd.ld_write;
   assign bkt_wr_addr = cmd.clr_step ? clr_ff : hash_ff;
   assign bkt_wr_data = cmd.clr_step ? '0
                      : {1'b1, (bkt_used ? bkt_head : pos_ff), pos_ff};

   pchl_ram #(.WIDTH(24), .DEPTH(PALETTE_ENTRIES)) u_colour_ram (
      .clock   (clock),
      .wr_en   (cmd.ld_write),
      .wr_addr (pos_ff),
      .wr_data (colour_ff),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (colour_rd)
   );

   pchl_ram #(.WIDTH(LW), .DEPTH(PALETTE_ENTRIES)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (link_rd)
   );

   pchl_ram #(.WIDTH(BW), .DEPTH(PALETTE_ENTRIES)) u_bucket_ram (
      .clock   (clock),
      .wr_en   (bkt_wr_en),
      .wr_addr (bkt_wr_addr),
      .wr_data (bkt_wr_data),
      .rd_en   (cmd.bkt_rd),
      .rd_addr (hash_ff),
      .rd_data (bkt_rd)
   );

   // load position and palette state
   always_comb begin
      pos_in      = pos_ff;
      complete_in = complete_ff;
      clr_in      = clr_ff;
      if (cmd.clr_start) begin
         clr_in      = '0;
         pos_in      = '0;
         complete_in = 1'b0;
      end else if (cmd.clr_step) begin
         clr_in = clr_ff + 1'b1;
      end
      if (cmd.rsp_load && cmd.rsp_code == RSP_LOAD) begin
         if (pos_ff == LAST_POS) begin
            pos_in      = '0;
            complete_in = 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         case (cmd.rsp_code)
            RSP_LOAD: begin
               rsp_status_in = STATUS_OK;
               rsp_index_in  = 8'(pos_ff);
            end
            RSP_FOUND: begin
               rsp_status_in = STATUS_OK;
               rsp_index_in  = 8'(cur_ff);
            end
            RSP_NOT_LOADED: begin
               rsp_status_in = STATUS_NOT_LOADED;
               rsp_index_in  = '0;
            end
            default: begin
               rsp_status_in = STATUS_NOT_FOUND;
               rsp_index_in  = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         complete_ff  <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         complete_ff  <= complete_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff    <= req_tuser;
         colour_ff <= req_tdata;
         sum_ff    <= sum_in;
      end
      if (cmd.hash_mult) begin
         prod_ff <= prod_in;
      end
      if (cmd.hash_reduce) begin
         hash_ff <= hash_in;
      end
      cur_ff        <= cur_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
   end

   assign sts.is_lookup  = (cmd_ff == CMD_LOOKUP);
   assign sts.complete   = complete_ff;
   assign sts.clear_last = (clr_ff == LAST_POS);
   assign sts.used       = bkt_used;
   assign sts.match      = (colour_rd == colour_ff);
   assign sts.next_end   = (link_rd >= LINK_END);
   assign sts.rsp_busy   = rsp_valid_ff & ~rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_index_ff;

endmodule

`default_nettype wire

@@ rtl/palette_color_hash_lookup.sv @@
// Top level of the palette color hash lookup: controller plus datapath.
// Depends on pchl_pkg, pchl_ctrl, pchl_dp (and pchl_ram through pchl_dp).
//
//   channel | dir | tdata                   | tuser
//   --------+-----+-------------------------+----------------------------
//   req_    | in  | red, green, blue (24b)  | cmd: 0 load, 1 lookup
//   rsp_    | out | index (8b)              | status: 0 ok, 1 miss, 2 not loaded
//
// One item at a time; req_tready is high only in idle. A load writes its entry and
// bucket word, plus a tail link when the bucket already holds a chain; the first load
// of a new palette first clears every bucket. A lookup walks the bucket's chain entry by
// entry; on an incomplete palette it answers not loaded without a walk.
// After reset a bucket clear runs with req_tready low.
// A stalled result waits in the output register; the next item runs and holds until it drains.
`default_nettype none

module palette_color_hash_lookup #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [7:0] red, [15:8] green, [23:16] blue
   input  wire logic        req_tuser,   // [0] cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] index
   output logic [1:0]       rsp_tuser    // [1:0] status
);
   import pchl_pkg::*;

   pchl_cmd_type cmd;
   pchl_sts_type sts;

   pchl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pchl_dp #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
